/* rtl/gta_pkg.sv */
// Shared types, register indexes and reset values of the gamepad turbo autofire block.
package gta_pkg;

    localparam int unsigned DEF_NUM_CONTROLLERS = 4;
    localparam int unsigned DEF_TIME_BITS       = 32;

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_MASK   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_TARGET   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BTN_TARGET    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_SELECT   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESH  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THRESH = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_TIMING   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BTN_TIMING    = 4'd7;

    localparam logic [15:0] RST_TOGGLE_MASK   = 16'h1100;
    localparam logic [15:0] RST_TRIG_TARGET   = 16'hF00F;
    localparam logic [15:0] RST_BTN_TARGET    = 16'h0000;
    localparam logic [1:0]  RST_TRIG_SELECT   = 2'd3;
    localparam logic [7:0]  RST_PRESS_THRESH  = 8'd30;
    localparam logic [7:0]  RST_RELEASE_THRESH = 8'd20;
    localparam logic [47:0] RST_TIMING        = 48'h0000_0021_0021;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_ENABLE  = 2'd1;
    localparam logic [1:0] EV_DISABLE = 2'd2;
    localparam logic [1:0] EV_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]  controller;
        logic [15:0] buttons_in;
        logic [7:0]  left_trigger;
        logic [7:0]  right_trigger;
        logic [31:0] now_ms;
        logic [31:0] packet_in;
    } t_poll;

    typedef struct packed {
        logic [15:0] buttons_out;
        logic [31:0] packet_out;
        logic [1:0]  toggle_event;
    } t_result;

endpackage

/* rtl/gamepad_turbo_autofire.sv */
// Top level: turbo autofire sequencer with one shared phase-clock working copy and remainder unit.
// The bit-serial remainder unit (one quotient bit per cycle) reduces the elapsed time by whole
// periods when a phase clock catches up; pass-through polls skip it.
// Throughput: one poll at a time; the next transfer is taken once the result sits in
// the output register. Reset (synchronous, active low) clears all controller state.
module gamepad_turbo_autofire #(
    parameter int unsigned NUM_CONTROLLERS = gta_pkg::DEF_NUM_CONTROLLERS,
    parameter int unsigned TIME_BITS       = gta_pkg::DEF_TIME_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  gta_pkg::t_poll                  i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output gta_pkg::t_result                o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gta_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gta_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import gta_pkg::*;

    localparam int unsigned N    = NUM_CONTROLLERS;
    localparam int unsigned TB   = TIME_BITS;
    localparam int unsigned IW   = (N > 1) ? $clog2(N) : 1;
    localparam int unsigned AW   = TB + 1;
    localparam int unsigned RW   = 18;
    localparam int unsigned CNTW = $clog2(TB + 1);

    // One-hot sequencer.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_CLK   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_FIN   = 7'b0010000,
        S_STORE = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [15:0] r_toggle_mask, r_trig_target, r_btn_target;
    logic [1:0]  r_trig_select;
    logic [7:0]  r_press_thresh, r_release_thresh;
    logic [47:0] r_trig_timing, r_btn_timing;

    // Per-controller state.
    logic          r_master;
    logic          r_trig_active [N];
    logic          r_t_on [N], r_t_started [N], r_t_first [N];
    logic [TB-1:0] r_t_start [N];
    logic          r_b_on [N], r_b_started [N], r_b_first [N];
    logic [TB-1:0] r_b_start [N];
    logic [15:0]   r_last_out [N], r_last_in [N];

    // Item under work.
    t_poll         r_in;
    logic [IW-1:0] r_idx;
    logic [TB-1:0] r_now;
    logic [15:0]   r_trig_owned, r_btn_owned;
    logic          r_sel;      // 0: trigger clock, 1: button clock
    t_result       r_res;

    // Working copy of the selected phase clock and the remainder unit.
    logic          r_w_on, r_w_started, r_w_first;
    logic [TB-1:0] r_w_start;
    logic [TB-1:0] r_e;
    logic [RW-1:0] r_rem;
    logic [CNTW-1:0] r_cnt;

    logic    r_ovalid;
    t_result r_out;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // Timing decode for the selected mode; zero lengths become 1 ms.
    logic [47:0] w_timing;
    logic [15:0] w_on_raw, w_first_raw, w_onl, w_offl, w_firstl, w_cur, w_cur2;
    logic [16:0] w_period;
    logic [15:0] w_owned;
    logic [TB-1:0] w_elapsed;
    logic [RW-1:0] w_rem_sh;

    always_comb begin
        w_timing    = r_sel ? r_btn_timing : r_trig_timing;
        w_on_raw    = w_timing[31:16];
        w_first_raw = (w_timing[47:32] == 16'd0) ? w_on_raw : w_timing[47:32];
        w_onl       = (w_on_raw == 16'd0) ? 16'd1 : w_on_raw;
        w_offl      = (w_timing[15:0] == 16'd0) ? 16'd1 : w_timing[15:0];
        w_firstl    = (w_first_raw == 16'd0) ? 16'd1 : w_first_raw;
        w_period    = {1'b0, w_onl} + {1'b0, w_offl};
        w_owned     = r_sel ? r_btn_owned : r_trig_owned;
        w_elapsed   = r_now - r_w_start;
        w_cur       = (r_w_on && r_w_first) ? w_firstl : (r_w_on ? w_onl : w_offl);
        w_cur2      = r_w_on ? w_onl : w_offl;
        w_rem_sh    = {r_rem[RW-2:0], r_e[TB-1]};
    end

    // Poll decode for the prepare step.
    logic        w_in_range, w_edge;
    logic [7:0]  w_trig;
    logic        w_act;
    logic [15:0] w_trig_owned, w_tm;

    always_comb begin
        w_tm       = r_toggle_mask;
        w_in_range = (32'(r_in.controller) < N);
        w_edge     = (w_tm != 16'd0) && ((r_in.buttons_in & w_tm) == w_tm)
                     && ((r_last_in[r_idx] & w_tm) != w_tm);
        w_trig     = 8'd0;
        if (r_trig_select[1] && (r_in.right_trigger > w_trig)) begin
            w_trig = r_in.right_trigger;
        end
        if (r_trig_select[0] && (r_in.left_trigger > w_trig)) begin
            w_trig = r_in.left_trigger;
        end
        w_act        = r_trig_active[r_idx] ? (w_trig >= r_release_thresh)
                                            : (w_trig >= r_press_thresh);
        w_trig_owned = w_act ? (r_in.buttons_in & r_trig_target) : 16'd0;
    end

    // Final button image from the stored trigger clock and the button clock in the working copy.
    logic [15:0] w_b;
    always_comb begin
        w_b = r_in.buttons_in;
        w_b = r_t_on[r_idx] ? (w_b | r_trig_owned) : (w_b & ~r_trig_owned);
        w_b = r_w_on ? (w_b | r_btn_owned) : (w_b & ~r_btn_owned);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_ovalid         <= 1'b0;
            r_master         <= 1'b0;
            r_sel            <= 1'b0;
            r_toggle_mask    <= RST_TOGGLE_MASK;
            r_trig_target    <= RST_TRIG_TARGET;
            r_btn_target     <= RST_BTN_TARGET;
            r_trig_select    <= RST_TRIG_SELECT;
            r_press_thresh   <= RST_PRESS_THRESH;
            r_release_thresh <= RST_RELEASE_THRESH;
            r_trig_timing    <= RST_TIMING;
            r_btn_timing     <= RST_TIMING;
            for (int i = 0; i < N; i++) begin
                r_trig_active[i] <= 1'b0;
                r_t_on[i]        <= 1'b0;
                r_t_started[i]   <= 1'b0;
                r_t_first[i]     <= 1'b0;
                r_t_start[i]     <= '0;
                r_b_on[i]        <= 1'b0;
                r_b_started[i]   <= 1'b0;
                r_b_first[i]     <= 1'b0;
                r_b_start[i]     <= '0;
                r_last_out[i]    <= 16'd0;
                r_last_in[i]     <= 16'd0;
            end
        end else begin
            // Configuration writes; indexes past the list are dropped.
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TOGGLE_MASK:    r_toggle_mask    <= i_cfg_data[15:0];
                    REG_TRIG_TARGET:    r_trig_target    <= i_cfg_data[15:0];
                    REG_BTN_TARGET:     r_btn_target     <= i_cfg_data[15:0];
                    REG_TRIG_SELECT:    r_trig_select    <= i_cfg_data[1:0];
                    REG_PRESS_THRESH:   r_press_thresh   <= i_cfg_data[7:0];
                    REG_RELEASE_THRESH: r_release_thresh <= i_cfg_data[7:0];
                    REG_TRIG_TIMING:    r_trig_timing    <= i_cfg_data;
                    REG_BTN_TIMING:     r_btn_timing     <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop the result once taken; S_DONE drives the flag itself.
            if (r_ovalid && i_out_ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in;
                        r_idx   <= IW'(i_in.controller);
                        r_now   <= TB'(i_in.now_ms);
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    // Default: pass the poll through; a combo edge reports the new master.
                    r_res <= '{buttons_out: r_in.buttons_in, packet_out: r_in.packet_in,
                               toggle_event: (w_in_range && w_edge)
                                             ? (r_master ? EV_DISABLE : EV_ENABLE)
                                             : EV_NONE};
                    if (!w_in_range) begin
                        r_state <= S_DONE;
                    end else if (w_edge) begin
                        r_master         <= !r_master;
                        r_last_in[r_idx] <= r_in.buttons_in;
                        if (r_master) begin
                            r_trig_active[r_idx] <= 1'b0;
                            r_t_started[r_idx]   <= 1'b0;
                            r_t_first[r_idx]     <= 1'b0;
                            r_b_started[r_idx]   <= 1'b0;
                            r_b_first[r_idx]     <= 1'b0;
                        end
                        r_state <= S_DONE;
                    end else if (!r_master) begin
                        r_last_in[r_idx] <= r_in.buttons_in;
                        r_state <= S_DONE;
                    end else begin
                        r_last_in[r_idx]     <= r_in.buttons_in;
                        r_trig_active[r_idx] <= w_act;
                        r_trig_owned         <= w_trig_owned;
                        r_btn_owned          <= r_in.buttons_in & r_btn_target & ~w_trig_owned;
                        r_sel                <= 1'b0;
                        r_w_on               <= r_t_on[r_idx];
                        r_w_started          <= r_t_started[r_idx];
                        r_w_first            <= r_t_first[r_idx];
                        r_w_start            <= r_t_start[r_idx];
                        r_state              <= S_CLK;
                    end
                end
                S_CLK: begin
                    if (w_owned == 16'd0) begin
                        r_w_started <= 1'b0;
                        r_w_first   <= 1'b0;
                        r_state     <= S_STORE;
                    end else if (!r_w_started) begin
                        r_w_on      <= 1'b1;
                        r_w_first   <= 1'b1;
                        r_w_start   <= r_now;
                        r_w_started <= 1'b1;
                        r_state     <= S_STORE;
                    end else if ({1'b0, w_elapsed} < AW'(w_cur)) begin
                        r_state <= S_STORE;
                    end else begin
                        // Leave the current phase, then reduce the rest by whole periods.
                        r_w_first <= 1'b0;
                        r_w_on    <= !r_w_on;
                        r_e       <= w_elapsed - TB'(w_cur);
                        r_rem     <= '0;
                        r_cnt     <= CNTW'(TB);
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    // One remainder bit per cycle.
                    if (w_rem_sh >= RW'(w_period)) begin
                        r_rem <= w_rem_sh - RW'(w_period);
                    end else begin
                        r_rem <= w_rem_sh;
                    end
                    r_e   <= {r_e[TB-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Phase start lands at now minus the leftover past any phase it completes.
                    if (r_rem >= RW'(w_cur2)) begin
                        r_w_start <= r_now - TB'(r_rem) + TB'(w_cur2);
                        r_w_on    <= !r_w_on;
                    end else begin
                        r_w_start <= r_now - TB'(r_rem);
                    end
                    r_state <= S_STORE;
                end
                S_STORE: begin
                    if (!r_sel) begin
                        r_t_on[r_idx]      <= r_w_on;
                        r_t_started[r_idx] <= r_w_started;
                        r_t_first[r_idx]   <= r_w_first;
                        r_t_start[r_idx]   <= r_w_start;
                        r_sel              <= 1'b1;
                        r_w_on             <= r_b_on[r_idx];
                        r_w_started        <= r_b_started[r_idx];
                        r_w_first          <= r_b_first[r_idx];
                        r_w_start          <= r_b_start[r_idx];
                        r_state            <= S_CLK;
                    end else begin
                        r_b_on[r_idx]      <= r_w_on;
                        r_b_started[r_idx] <= r_w_started;
                        r_b_first[r_idx]   <= r_w_first;
                        r_b_start[r_idx]   <= r_w_start;
                        r_last_out[r_idx]  <= w_b;
                        r_res.buttons_out  <= w_b;
                        r_res.packet_out   <= (w_b != r_last_out[r_idx])
                                              ? r_in.packet_in + 32'd1 : r_in.packet_in;
                        r_state            <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free.
                    if (!r_ovalid || i_out_ready) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/gta_checker.sv */
// Port-level checker for the gamepad turbo autofire block and its bind.
module gta_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input gta_pkg::t_result      o_out,
    input logic                  o_cfg_ready
);
    import gta_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed while stalled");

    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.toggle_event != EV_UNUSED)
        else $error("undefined toggle event code");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("poll taken while previous still in work");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind gamepad_turbo_autofire gta_checker u_gta_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out),
    .o_cfg_ready (o_cfg_ready)
);

/* tb/gamepad_turbo_autofire_tb.sv */
// Testbench for the gamepad turbo autofire block: directed and random polls checked against a predictor.
`timescale 1ns / 100ps

module gamepad_turbo_autofire_tb;
    import gta_pkg::*;

    localparam int NCTL = 4;
    localparam longint unsigned CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 120;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_poll i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_result o_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    gamepad_turbo_autofire dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the configuration registers.
    logic [15:0] combo_mask, trig_tgt, btn_tgt;
    logic [1:0]  trig_sel;
    logic [7:0]  press_lvl, release_lvl;
    logic [47:0] trig_tim, btn_tim;

    // Predictor copy of the per-controller state.
    typedef struct {
        bit on;
        bit started;
        bit first;
        logic [31:0] start;
    } t_phase;

    bit          turbo_on;
    bit          trig_act [NCTL];
    t_phase      trig_ph [NCTL];
    t_phase      btn_ph [NCTL];
    logic [15:0] prev_out [NCTL];
    logic [15:0] prev_in [NCTL];

    t_result pending_results[$];
    int      fail_count = 0;
    longint unsigned cycle_count = 0;
    bit      clock_stress = 0;    // random side: back-to-back polls, receiver ready outside rare stalls

    function automatic logic [31:0] min_one(logic [31:0] v);
        return (v == 0) ? 32'd1 : v;
    endfunction

    // Advance one phase clock to now; drop state when nothing is owned.
    function automatic void advance_phase(ref t_phase c, input logic [15:0] owned,
                                          input logic [47:0] tim, input logic [31:0] now);
        logic [31:0] on_len, off_len, first_len, cur, el;
        logic [32:0] period;
        longint unsigned k;
        on_len    = {16'd0, tim[31:16]};
        off_len   = {16'd0, tim[15:0]};
        first_len = {16'd0, tim[47:32]};
        if (first_len == 0) first_len = on_len;
        on_len = min_one(on_len);
        off_len = min_one(off_len);
        first_len = min_one(first_len);
        if (owned == 0) begin
            c.started = 0;
            c.first = 0;
            return;
        end
        if (!c.started) begin
            c.on = 1;
            c.first = 1;
            c.start = now;
            c.started = 1;
            return;
        end
        el = now - c.start;
        cur = (c.on && c.first) ? first_len : (c.on ? on_len : off_len);
        if (el < cur) return;
        el -= cur;
        c.start += cur;
        c.first = 0;
        c.on = !c.on;
        period = on_len + off_len;
        k = el / period;
        el = el - 32'(k * period);
        c.start = c.start + 32'(k * period);
        cur = c.on ? on_len : off_len;
        if (el >= cur) begin
            c.start += cur;
            c.on = !c.on;
        end
    endfunction

    function automatic t_result predict_poll(t_poll p);
        t_result r;
        int ctl;
        logic [7:0] lvl;
        bit act;
        logic [15:0] b, t_owned, b_owned;
        r.buttons_out = p.buttons_in;
        r.packet_out = p.packet_in;
        r.toggle_event = EV_NONE;
        ctl = p.controller;
        if (ctl >= NCTL) return r;
        if (combo_mask != 0 && (p.buttons_in & combo_mask) == combo_mask
                && (prev_in[ctl] & combo_mask) != combo_mask) begin
            turbo_on = !turbo_on;
            if (!turbo_on) begin
                trig_act[ctl] = 0;
                trig_ph[ctl].started = 0;
                trig_ph[ctl].first = 0;
                btn_ph[ctl].started = 0;
                btn_ph[ctl].first = 0;
            end
            prev_in[ctl] = p.buttons_in;
            r.toggle_event = turbo_on ? EV_ENABLE : EV_DISABLE;
            return r;
        end
        prev_in[ctl] = p.buttons_in;
        if (!turbo_on) return r;
        lvl = 0;
        if (trig_sel[1] && p.right_trigger > lvl) lvl = p.right_trigger;
        if (trig_sel[0] && p.left_trigger > lvl) lvl = p.left_trigger;
        act = trig_act[ctl] ? (lvl >= release_lvl) : (lvl >= press_lvl);
        trig_act[ctl] = act;
        t_owned = act ? (p.buttons_in & trig_tgt) : 16'd0;
        b_owned = p.buttons_in & btn_tgt & ~t_owned;
        advance_phase(trig_ph[ctl], t_owned, trig_tim, p.now_ms);
        advance_phase(btn_ph[ctl], b_owned, btn_tim, p.now_ms);
        b = p.buttons_in;
        b = trig_ph[ctl].on ? (b | t_owned) : (b & ~t_owned);
        b = btn_ph[ctl].on ? (b | b_owned) : (b & ~b_owned);
        if (b != prev_out[ctl]) r.packet_out = p.packet_in + 1;
        prev_out[ctl] = b;
        r.buttons_out = b;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (clock_stress) return 0;
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one poll; the expectation is queued at the transfer edge.
    task automatic send_poll(t_poll p);
        int gap;
        gap = pick_gap();
        repeat (gap + 1) @(negedge i_clk);
        i_in <= p;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(predict_poll(p));
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write one register while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
        wait_drained();
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_TOGGLE_MASK:    combo_mask = val[15:0];
            REG_TRIG_TARGET:    trig_tgt = val[15:0];
            REG_BTN_TARGET:     btn_tgt = val[15:0];
            REG_TRIG_SELECT:    trig_sel = val[1:0];
            REG_PRESS_THRESH:   press_lvl = val[7:0];
            REG_RELEASE_THRESH: release_lvl = val[7:0];
            REG_TRIG_TIMING:    trig_tim = val;
            REG_BTN_TIMING:     btn_tim = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_poll make_poll(logic [1:0] ctl, logic [15:0] btn, logic [7:0] lt,
                                        logic [7:0] rt, logic [31:0] now);
        t_poll p;
        p.controller = ctl;
        p.buttons_in = btn;
        p.left_trigger = lt;
        p.right_trigger = rt;
        p.now_ms = now;
        p.packet_in = $urandom();
        return p;
    endfunction

    // Hold the receiver side: random stalls, with stall-free stretches.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge i_clk);
            end else begin
                i_out_ready <= (clock_stress || $urandom_range(0, 99) < 70);
            end
        end
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result buttons_out=%h", o_out.buttons_out);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_out.buttons_out !== exp_r.buttons_out) begin
                    $error("buttons_out exp %h got %h", exp_r.buttons_out, o_out.buttons_out);
                    fail_count++;
                end
                if (o_out.packet_out !== exp_r.packet_out) begin
                    $error("packet_out exp %h got %h", exp_r.packet_out, o_out.packet_out);
                    fail_count++;
                end
                if (o_out.toggle_event !== exp_r.toggle_event) begin
                    $error("toggle_event exp %0d got %0d", exp_r.toggle_event,
                           o_out.toggle_event);
                    fail_count++;
                end
            end
        end
    end

    // Abort on a hang.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Field extremes, combo edges, time wrap and zero durations.
    task automatic test_directed();
        logic [31:0] t;
        t = 32'hFFFF_FFF0;
        send_poll(make_poll(2'd0, 16'hFFFF, 8'hFF, 8'hFF, 32'h0));   // combo edge: enable
        send_poll(make_poll(2'd0, 16'hFFFF, 8'hFF, 8'hFF, 32'h0));   // held combo, no edge
        send_poll(make_poll(2'd1, 16'hF00F, 8'd30, 8'd0, t));
        send_poll(make_poll(2'd1, 16'hF00F, 8'd25, 8'd0, t + 32'd20));  // still above release
        send_poll(make_poll(2'd1, 16'hF00F, 8'd19, 8'd0, t + 32'd40));  // release wraps time
        send_poll(make_poll(2'd2, 16'hF00F, 8'd0, 8'd29, 32'd5));
        send_poll(make_poll(2'd2, 16'hF00F, 8'd0, 8'd30, 32'd6));
        send_poll(make_poll(2'd2, 16'hF00F, 8'd0, 8'd255, 32'd5000)); // catch-up
        send_poll(make_poll(2'd3, 16'h0000, 8'd0, 8'd0, 32'hFFFF_FFFF));
        send_poll(make_poll(2'd3, 16'h1100, 8'd0, 8'd0, 32'd1));      // combo edge: disable
        send_poll(make_poll(2'd3, 16'hF00F, 8'd200, 8'd200, 32'd2));  // master off
        write_reg(REG_TRIG_TIMING, 48'h0);                            // all zero durations
        write_reg(REG_BTN_TIMING, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_BTN_TARGET, 48'hFFFF);
        write_reg(REG_TOGGLE_MASK, 48'h0);                            // toggling off
        send_poll(make_poll(2'd0, 16'h1100, 8'd0, 8'd0, 32'd3));
        for (int i = 0; i < 6; i++)
            send_poll(make_poll(2'd0, 16'hFFFF, 8'd255, 8'd0, 32'(10 + i * 3)));
        send_poll(make_poll(2'd0, 16'h0FF0, 8'd0, 8'd0, 32'd100));
        send_poll(make_poll(2'd0, 16'h0FF0, 8'd0, 8'd0, 32'd70000));
    endtask

    function automatic logic [47:0] rand_timing();
        logic [47:0] v;
        int s;
        s = $urandom_range(0, 9);
        v[47:32] = (s == 0) ? 16'd0 : 16'($urandom_range(0, 40));
        v[31:16] = (s == 1) ? 16'd0 : 16'($urandom_range(1, 40));
        v[15:0]  = (s == 2) ? 16'd0 : 16'($urandom_range(1, 40));
        if (s == 3) v = 48'({$urandom(), $urandom()});
        return v;
    endfunction

    task automatic test_random_phase(int n_polls);
        logic [31:0] clk_ms [NCTL];
        logic [15:0] held [NCTL];
        t_poll p;
        int c;
        for (int i = 0; i < NCTL; i++) begin
            clk_ms[i] = $urandom();
            held[i] = 16'($urandom());
        end
        for (int i = 0; i < n_polls; i++) begin
            c = $urandom_range(0, NCTL - 1);
            // mostly steady holds with time moving forward, some noise
            case ($urandom_range(0, 9))
                0: held[c] = 16'($urandom());
                1: held[c] = held[c] ^ (16'd1 << $urandom_range(0, 15));
                2: held[c] = combo_mask | 16'($urandom());
                default: ;
            endcase
            case ($urandom_range(0, 9))
                0: clk_ms[c] = clk_ms[c] + $urandom_range(0, 5000);
                1: clk_ms[c] = $urandom();
                default: clk_ms[c] = clk_ms[c] + $urandom_range(0, 30);
            endcase
            p = make_poll(2'(c), held[c], 8'($urandom()), 8'($urandom()), clk_ms[c]);
            if ($urandom_range(0, 3) == 0) begin
                p.left_trigger = 8'($urandom_range(0, 40));
                p.right_trigger = 8'($urandom_range(0, 40));
            end
            send_poll(p);
        end
    endtask

    task automatic test_config_sweeps();
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(REG_TOGGLE_MASK, (phase == 5) ? 48'hFFFF
                                       : (phase % 2) ? 48'h1100 : 48'h0001 << phase);
            write_reg(REG_TRIG_TARGET, (phase == 0) ? 48'h0 : 48'($urandom()));
            write_reg(REG_BTN_TARGET, (phase == 1) ? 48'hFFFF : 48'($urandom()));
            write_reg(REG_TRIG_SELECT, 48'(phase % 4));
            write_reg(REG_PRESS_THRESH, (phase == 2) ? 48'd0 : (phase == 3) ? 48'd255
                                        : 48'($urandom_range(10, 40)));
            write_reg(REG_RELEASE_THRESH, (phase == 2) ? 48'd255 : (phase == 3) ? 48'd0
                                          : 48'($urandom_range(5, 30)));
            write_reg(REG_TRIG_TIMING, rand_timing());
            write_reg(REG_BTN_TIMING, rand_timing());
            clock_stress = (phase == 4);
            test_random_phase(270);
            clock_stress = 0;
        end
    endtask

    initial begin
        combo_mask = RST_TOGGLE_MASK;
        trig_tgt = RST_TRIG_TARGET;
        btn_tgt = RST_BTN_TARGET;
        trig_sel = RST_TRIG_SELECT;
        press_lvl = RST_PRESS_THRESH;
        release_lvl = RST_RELEASE_THRESH;
        trig_tim = RST_TIMING;
        btn_tim = RST_TIMING;
        turbo_on = 0;
        for (int i = 0; i < NCTL; i++) begin
            trig_act[i] = 0;
            trig_ph[i] = '{0, 0, 0, 32'd0};
            btn_ph[i] = '{0, 0, 0, 32'd0};
            prev_out[i] = 0;
            prev_in[i] = 0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_config_sweeps();
        wait_drained();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/gta_pkg.sv
rtl/gamepad_turbo_autofire.sv
rtl/gta_checker.sv
tb/gamepad_turbo_autofire_tb.sv
